// ===== rtl/crc16fe_pkg.sv =====
// shared types, constants and crc update function for the crc16 frame engine
`timescale 1ns / 1ps
`default_nettype none

package crc16fe_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] MODE_COMPUTE = 2'd0;
  localparam logic [1:0] MODE_APPEND  = 2'd1;
  localparam logic [1:0] MODE_CHECK   = 2'd2;

  localparam logic REG_CRC_MODE = 1'b0;
  localparam logic REG_TAIL_LE  = 1'b1;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned MAXRES = 3;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_summary;
    logic [15:0] crc_value;
    logic        crc_ok;
    logic        too_short;
    logic        last_of_run;
  } res_t;

  // one byte of reflected crc-16, bit at a time
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/crc16_frame_engine.sv =====
// crc16 frame engine top level: frame state, result building and result queue
//
// byte stream in on in_*: in_tdata is one frame byte, in_tlast marks the last
// byte of a frame. results leave on out_*, one per cycle while out_tready is
// high, in the same order. compute and check modes give one byte result per
// input byte, and a frame summary (out_tuser high) after the last byte. append
// mode delays the stream by two bytes and puts the crc in place of the final
// two bytes; a one-byte frame passes through, flagged too_short. the crc update
// is one unrolled byte step, so an input byte is taken every cycle while a
// request yields one result and out_tready is high; a last byte can yield up
// to three results. results are queued on acceptance and leave behind older ones.
// results sit in a four-entry queue; in_tready is high while at most one entry
// is waiting, so a stalled receiver backs the input up once two results wait.
// cfg_* writes are taken at once and should only be done with the block idle.
// reset empties the queue, restarts the frame, sets compute mode and low byte
// first tail order.
`timescale 1ns / 1ps
`default_nettype none

module crc16_frame_engine import crc16fe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] out_byte, [23:8] crc_value,
                                       // [24] crc_ok, [25] too_short, zero above
  output logic             out_tuser,  // [0] is_summary
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_wdata
);

  logic [1:0]  crc_mode_r;
  logic        tail_le_r;

  logic [15:0] run_r, run_nxt;
  logic [15:0] body_r, body_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [1:0]  seen_r, seen_nxt;

  res_t        qmem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r, count_nxt;

  res_t        res [MAXRES];
  logic [1:0]  push_n;
  logic        acc, pop;
  logic        is_append, is_check;
  logic [15:0] full_crc, body_crc, tail;
  logic [7:0]  t0, lo, hi;
  res_t        zero_res;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_mode_r <= MODE_COMPUTE;
      tail_le_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CRC_MODE: crc_mode_r <= cfg_wdata;
        REG_TAIL_LE:  tail_le_r  <= cfg_wdata[0];
      endcase
    end
  end

  assign in_tready = (count_r <= (QAW+1)'(1));
  assign acc       = in_tvalid && in_tready;
  assign out_tvalid = (count_r != '0);
  assign pop       = out_tvalid && out_tready;

  assign is_append = (crc_mode_r == MODE_APPEND);
  assign is_check  = (crc_mode_r == MODE_CHECK);

  assign full_crc = crc_byte(run_r, in_tdata);
  assign body_crc = (seen_r == 2'd2) ? body_r : CRC_INIT;
  assign t0       = (seen_r == 2'd2) ? held1_r : held0_r;
  assign tail     = tail_le_r ? {in_tdata, t0} : {t0, in_tdata};
  assign lo       = body_crc[7:0];
  assign hi       = body_crc[15:8];
  assign zero_res = '0;

  // frame state and results of one request
  always_comb begin
    run_nxt   = run_r;
    body_nxt  = body_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    seen_nxt  = seen_r;
    push_n    = 2'd0;
    for (int k = 0; k < MAXRES; k++) begin
      res[k] = zero_res;
    end

    if (!in_tlast) begin
      run_nxt = full_crc;
      unique case (seen_r)
        2'd0: begin
          held0_nxt = in_tdata;
          body_nxt  = full_crc;
          seen_nxt  = 2'd1;
        end
        2'd1: begin
          held1_nxt = in_tdata;
          seen_nxt  = 2'd2;
        end
        default: begin
          held0_nxt = held1_r;
          held1_nxt = in_tdata;
          body_nxt  = run_r;
        end
      endcase
      if (is_append) begin
        if (seen_r == 2'd2) begin
          res[0].out_byte = held0_r;
          push_n = 2'd1;
        end
      end else begin
        res[0].out_byte = in_tdata;
        push_n = 2'd1;
      end
    end else begin
      run_nxt   = CRC_INIT;
      body_nxt  = CRC_INIT;
      held0_nxt = '0;
      held1_nxt = '0;
      seen_nxt  = 2'd0;
      if (is_append) begin
        if (seen_r == 2'd0) begin
          res[0].out_byte    = in_tdata;
          res[0].crc_value   = CRC_INIT;
          res[0].too_short   = 1'b1;
          res[0].last_of_run = 1'b1;
          push_n = 2'd1;
        end else if (seen_r == 2'd2) begin
          res[0].out_byte    = held0_r;
          res[1].out_byte    = tail_le_r ? lo : hi;
          res[2].out_byte    = tail_le_r ? hi : lo;
          res[2].crc_value   = body_crc;
          res[2].last_of_run = 1'b1;
          push_n = 2'd3;
        end else begin
          res[0].out_byte    = tail_le_r ? lo : hi;
          res[1].out_byte    = tail_le_r ? hi : lo;
          res[1].crc_value   = body_crc;
          res[1].last_of_run = 1'b1;
          push_n = 2'd2;
        end
      end else begin
        res[0].out_byte    = in_tdata;
        res[1].is_summary  = 1'b1;
        res[1].last_of_run = 1'b1;
        push_n = 2'd2;
        if (is_check) begin
          if (seen_r == 2'd0) begin
            res[1].crc_value = CRC_INIT;
            res[1].too_short = 1'b1;
          end else begin
            res[1].crc_value = body_crc;
            res[1].crc_ok    = (body_crc == tail);
          end
        end else begin
          res[1].crc_value = full_crc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= CRC_INIT;
      body_r  <= CRC_INIT;
      held0_r <= '0;
      held1_r <= '0;
      seen_r  <= 2'd0;
    end else if (acc) begin
      run_r   <= run_nxt;
      body_r  <= body_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int k = 0; k < MAXRES; k++) begin
        if (2'(k) < push_n) begin
          qmem_r[wr_ptr_r + QAW'(k)] <= res[k];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (acc) begin
      count_nxt = count_nxt + (QAW+1)'(push_n);
    end
    if (pop) begin
      count_nxt = count_nxt - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (acc) begin
        wr_ptr_r <= wr_ptr_r + QAW'(push_n);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_nxt;
    end
  end

  assign out_tdata = {6'd0, qmem_r[rd_ptr_r].too_short, qmem_r[rd_ptr_r].crc_ok,
                      qmem_r[rd_ptr_r].crc_value, qmem_r[rd_ptr_r].out_byte};
  assign out_tuser = qmem_r[rd_ptr_r].is_summary;
  assign out_tlast = qmem_r[rd_ptr_r].last_of_run;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_nxt <= (QAW+1)'(QDEPTH))
    else $error("result queue overflow");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tlast |=> seen_r == 2'd0 && run_r == CRC_INIT && body_r == CRC_INIT)
    else $error("frame state not restarted after last byte");

  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r != 2'd3)
    else $error("byte count out of range");

  a_stream_one: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_tlast && !is_append |-> push_n == 2'd1)
    else $error("body byte not passed through");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the crc16 frame engine: directed, stalled and random frames
`timescale 1ns / 1ps

module testbench import crc16fe_pkg::*; ;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 250;
  localparam int QUIET_ITEMS = 60;
  localparam int LONG_HOLD = 200;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PRINT_LIMIT = 50;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [1:0]  cfg_wdata = '0;

  crc16_frame_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor state and register mirror
  logic [1:0]  cur_mode;
  logic        tail_lo_first;
  logic [15:0] frame_crc;
  logic [7:0]  delay_q [2];
  int unsigned delay_fill;
  res_t        results_due [$];

  bit          in_idle_on;
  bit          out_idle_on;
  bit          hold_req;
  bit          hold_active;
  int unsigned errors;
  int unsigned results_seen;
  int unsigned bytes_sent;
  int unsigned frames_done;
  int unsigned frames_in_mode [4];
  int unsigned stall_cycles;

  initial forever #5 clk = ~clk;

  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc ^ {8'h00, d};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic void add_due(input logic [7:0] b, input logic summ,
                                  input logic [15:0] crc, input logic ok,
                                  input logic shrt, input logic last);
    res_t r;
    r.out_byte    = b;
    r.is_summary  = summ;
    r.crc_value   = crc;
    r.crc_ok      = ok;
    r.too_short   = shrt;
    r.last_of_run = last;
    results_due.push_back(r);
  endfunction

  function automatic void clear_frame_state();
    frame_crc  = CRC_INIT;
    delay_q[0] = '0;
    delay_q[1] = '0;
    delay_fill = 0;
  endfunction

  function automatic void predict_frame_byte(input logic [7:0] b, input logic fin);
    logic [1:0]  md;
    logic [7:0]  old;
    logic [7:0]  t0;
    logic [15:0] body;
    logic [15:0] whole;
    logic [15:0] tail;
    md = (cur_mode == MODE_UNUSED) ? MODE_COMPUTE : cur_mode;
    bytes_sent++;
    if (!fin) begin
      if (delay_fill == 2) begin
        old = delay_q[0];
        frame_crc = crc16_step(frame_crc, old);
        delay_q[0] = delay_q[1];
        delay_q[1] = b;
        if (md == MODE_APPEND) add_due(old, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      end else begin
        delay_q[delay_fill] = b;
        delay_fill++;
      end
      if (md != MODE_APPEND) add_due(b, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      return;
    end
    // crc over the body (all but the last two bytes) and over the whole frame
    body = frame_crc;
    if (delay_fill == 2) begin
      body = crc16_step(body, delay_q[0]);
      t0 = delay_q[1];
    end else begin
      t0 = delay_q[0];
    end
    tail = tail_lo_first ? {b, t0} : {t0, b};
    whole = frame_crc;
    for (int i = 0; i < int'(delay_fill); i++) whole = crc16_step(whole, delay_q[i]);
    whole = crc16_step(whole, b);
    if (md == MODE_COMPUTE) begin
      add_due(b, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      add_due('0, 1'b1, whole, 1'b0, 1'b0, 1'b1);
    end else if (md == MODE_CHECK) begin
      add_due(b, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      if (delay_fill == 0) add_due('0, 1'b1, CRC_INIT, 1'b0, 1'b1, 1'b1);
      else add_due('0, 1'b1, body, body == tail, 1'b0, 1'b1);
    end else begin
      if (delay_fill == 0) begin
        add_due(b, 1'b0, CRC_INIT, 1'b0, 1'b1, 1'b1);
      end else begin
        if (delay_fill == 2) add_due(delay_q[0], 1'b0, '0, 1'b0, 1'b0, 1'b0);
        if (tail_lo_first) begin
          add_due(body[7:0], 1'b0, '0, 1'b0, 1'b0, 1'b0);
          add_due(body[15:8], 1'b0, body, 1'b0, 1'b0, 1'b1);
        end else begin
          add_due(body[15:8], 1'b0, '0, 1'b0, 1'b0, 1'b0);
          add_due(body[7:0], 1'b0, body, 1'b0, 1'b0, 1'b1);
        end
      end
    end
    frames_in_mode[cur_mode]++;
    frames_done++;
    clear_frame_state();
  endfunction

  // overwrite the last two bytes with the crc of the rest in the current tail order
  function automatic void seal_frame(ref logic [7:0] frame [$]);
    logic [15:0] c;
    int n;
    n = frame.size();
    c = CRC_INIT;
    for (int i = 0; i < n - 2; i++) c = crc16_step(c, frame[i]);
    frame[n-2] = tail_lo_first ? c[7:0] : c[15:8];
    frame[n-1] = tail_lo_first ? c[15:8] : c[7:0];
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("[%0t] result %0d: %s got %0h want %0h", $time, results_seen, what, got, want);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_frame_byte(b, fin);
  endtask

  task automatic send_frame(input logic [7:0] frame [$]);
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CRC_MODE) cur_mode = val;
    else tail_lo_first = val[0];
    @(posedge clk);
  endtask

  task automatic test_compute_frames();
    logic [7:0] frame [$];
    write_reg(REG_CRC_MODE, MODE_COMPUTE);
    write_reg(REG_TAIL_LE, 2'd1);
    frame = {8'h00};
    send_frame(frame);
    frame = {8'hFF, 8'h00, 8'hFF};
    send_frame(frame);
    wait_idle();
  endtask

  task automatic test_append_frames();
    logic [7:0] frame [$];
    write_reg(REG_CRC_MODE, MODE_APPEND);
    // single byte passes through, two bytes become the crc of nothing
    frame = {8'hA5};
    send_frame(frame);
    frame = {8'h12, 8'h34};
    send_frame(frame);
    frame = {8'h00, 8'hFF, 8'h5A};
    send_frame(frame);
    wait_idle();
    write_reg(REG_TAIL_LE, 2'd0);
    frame = {8'hFF, 8'h00, 8'h81};
    send_frame(frame);
    wait_idle();
  endtask

  task automatic test_check_frames();
    logic [7:0] frame [$];
    write_reg(REG_CRC_MODE, MODE_CHECK);
    frame = {8'h7E};
    send_frame(frame);
    // empty body: tail ff ff matches the initial value
    frame = {8'hFF, 8'hFF};
    send_frame(frame);
    frame = {8'h01, 8'h00, 8'h00};
    seal_frame(frame);
    send_frame(frame);
    wait_idle();
    write_reg(REG_TAIL_LE, 2'd1);
    frame = {8'hC0, 8'h3F, 8'h00, 8'h00};
    seal_frame(frame);
    send_frame(frame);
    frame = {8'h00, 8'h01};
    send_frame(frame);
    wait_idle();
  endtask

  task automatic test_unused_mode();
    logic [7:0] frame [$];
    write_reg(REG_CRC_MODE, MODE_UNUSED);
    frame = {8'hC3, 8'h3C};
    send_frame(frame);
    wait_idle();
  endtask

  task automatic test_mode_switch_in_frame();
    write_reg(REG_CRC_MODE, MODE_COMPUTE);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    wait_idle();
    write_reg(REG_CRC_MODE, MODE_APPEND);
    send_byte(8'h33, 1'b0);
    wait_idle();
    write_reg(REG_CRC_MODE, MODE_CHECK);
    send_byte(8'h44, 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_reg(REG_CRC_MODE, MODE_COMPUTE);
    in_idle_on = 1'b0;
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    for (int i = 0; i < 24; i++) send_byte(8'($urandom_range(0, 255)), (i % 6) == 5);
    wait_idle();
    in_idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    logic [7:0] frame [$];
    int unsigned start;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      if (bytes_sent - start >= RANDOM_ITEMS - QUIET_ITEMS) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        write_reg(REG_CRC_MODE, 2'($urandom_range(0, 3)));
        if ($urandom_range(0, 1) == 0) write_reg(REG_TAIL_LE, 2'($urandom_range(0, 3)));
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      frame = {};
      repeat (len) frame.push_back(8'($urandom_range(0, 255)));
      if (cur_mode == MODE_CHECK && len >= 2 && $urandom_range(0, 3) != 0) seal_frame(frame);
      send_frame(frame);
    end
    wait_idle();
  endtask

  // receiver ready: random stalls, plus one long hold on request
  initial begin : rx_ready
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
      end else if (out_idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.out_byte    = out_tdata[7:0];
      got.crc_value   = out_tdata[23:8];
      got.crc_ok      = out_tdata[24];
      got.too_short   = out_tdata[25];
      got.is_summary  = out_tuser;
      got.last_of_run = out_tlast;
      results_seen++;
      if (out_tdata[31:26] != '0) report_mismatch("tdata padding", out_tdata[31:26], 0);
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result", got, 0);
      end else begin
        want = results_due.pop_front();
        if (got.out_byte != want.out_byte)
          report_mismatch("out_byte", got.out_byte, want.out_byte);
        if (got.is_summary != want.is_summary)
          report_mismatch("is_summary", got.is_summary, want.is_summary);
        if (got.crc_value != want.crc_value)
          report_mismatch("crc_value", got.crc_value, want.crc_value);
        if (got.crc_ok != want.crc_ok)
          report_mismatch("crc_ok", got.crc_ok, want.crc_ok);
        if (got.too_short != want.too_short)
          report_mismatch("too_short", got.too_short, want.too_short);
        if (got.last_of_run != want.last_of_run)
          report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $time, stall_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    cur_mode = MODE_COMPUTE;
    tail_lo_first = 1'b1;
    clear_frame_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    test_compute_frames();
    test_append_frames();
    test_check_frames();
    test_unused_mode();
    test_mode_switch_in_frame();
    test_backpressure();
    test_random_frames();
    if (results_due.size() != 0) report_mismatch("results never seen", results_due.size(), 0);
    $display("covered %0d frames, %0d bytes; compute/append/check/unused frames %0d/%0d/%0d/%0d",
             frames_done, bytes_sent, frames_in_mode[0], frames_in_mode[1],
             frames_in_mode[2], frames_in_mode[3]);
    $display("%0d results compared with %0d mismatches, including one long output stall",
             results_seen, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== crc16_frame_engine.f =====
rtl/crc16fe_pkg.sv
rtl/crc16_frame_engine.sv
dv/testbench.sv
